// File: rtl/char_property_line_parser_unit_assert.svh
// Assertion macros for the character property line parser.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CHAR_PROPERTY_LINE_PARSER_UNIT_ASSERT_SVH
`define CHAR_PROPERTY_LINE_PARSER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define CPLP_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cplp assertion failed");
`define CPLP_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("cplp assertion failed");
`else
`define CPLP_ASSERT(label, clk, rst_n, prop)
`define CPLP_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

// File: rtl/cplp_pkg.sv
// Shared types, constants and decode functions of the character property line parser.
// No dependencies.
`default_nettype none
package cplp_pkg;

  localparam int DIGITS_MAX_DEF  = 4;
  localparam int LETTERS_MAX_DEF = 2;

  localparam int CHAR_W = 8;
  localparam int CODE_W = 16;
  localparam int LINE_W = 20;
  localparam int CNT_W  = 2;

  localparam logic [CHAR_W-1:0] CHAR_SEMI    = 8'h3B;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [LINE_W-1:0] LINE_TOP     = {LINE_W{1'b1}};
  localparam logic [LINE_W-1:0] LINE_FIRST   = LINE_W'(1);

  typedef enum logic [1:0] {
    PH_CODE   = 2'd0,
    PH_NAME   = 2'd1,
    PH_LETTER = 2'd2,
    PH_EOL    = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    KIND_RECORD   = 2'd0,
    KIND_BAD_CODE = 2'd1,
    KIND_BAD_CAT  = 2'd2
  } kind_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  val;
  } hex_t;

  typedef struct packed {
    kind_t              kind;
    logic [CODE_W-1:0]  code_point;
    logic [CHAR_W-1:0]  letter_first;
    logic [CHAR_W-1:0]  letter_second;
    logic [CNT_W-1:0]   letter_count;
    logic [LINE_W-1:0]  line_number;
  } result_t;

  function automatic hex_t hex_decode(input logic [CHAR_W-1:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

  function automatic logic is_letter(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

endpackage
`default_nettype wire

// File: rtl/cplp_in_stage.sv
// Input register of the character property line parser.
// Depends on cplp_pkg.
`default_nettype none
module cplp_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cplp_pkg::CHAR_W-1:0] in_char_in,
  input  wire logic                        adv,
  output logic                             s1_valid,
  output logic [cplp_pkg::CHAR_W-1:0]      s1_char
);

  logic                        valid_r;
  logic                        valid_nxt;
  logic [cplp_pkg::CHAR_W-1:0] char_r;
  logic                        take;

  assign take      = !valid_r || adv;
  assign in_stall  = !take;
  assign valid_nxt = take ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_valid) begin
      char_r <= in_char_in;
    end
  end

  assign s1_valid = valid_r;
  assign s1_char  = char_r;

endmodule
`default_nettype wire

// File: rtl/cplp_parse_core.sv
// Parse state machine of the character property line parser: code point, name,
// category letters, end of line. Depends on cplp_pkg and the assertion header.
`default_nettype none
`include "char_property_line_parser_unit_assert.svh"
module cplp_parse_core #(
  parameter int DIGITS_MAX  = cplp_pkg::DIGITS_MAX_DEF,
  parameter int LETTERS_MAX = cplp_pkg::LETTERS_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        s1_valid,
  input  wire logic [cplp_pkg::CHAR_W-1:0] s1_char,
  input  wire logic                        adv,
  output logic                             res_valid,
  output cplp_pkg::result_t                res
);

  localparam int DCNT_W = $clog2(DIGITS_MAX + 1);
  localparam int LCNT_W = $clog2(LETTERS_MAX + 1);

  cplp_pkg::phase_t            phase_r, phase_nxt;
  logic [cplp_pkg::CODE_W-1:0] acc_r, acc_nxt;
  logic [DCNT_W-1:0]           dcnt_r, dcnt_nxt;
  logic [cplp_pkg::CHAR_W-1:0] let0_r, let0_nxt;
  logic [cplp_pkg::CHAR_W-1:0] let1_r, let1_nxt;
  logic [LCNT_W-1:0]           seen_r, seen_nxt;
  logic [cplp_pkg::LINE_W-1:0] line_r, line_nxt;

  logic                        fire;
  logic                        emit;
  cplp_pkg::hex_t              hex;
  logic [cplp_pkg::CNT_W-1:0]  cnt;

  assign fire = s1_valid && adv;
  assign hex  = cplp_pkg::hex_decode(s1_char);
  assign cnt  = (32'(seen_r) > 32'd3) ? 2'd3 : cplp_pkg::CNT_W'(seen_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cplp_pkg::PH_CODE;
      acc_r   <= '0;
      dcnt_r  <= '0;
      let0_r  <= '0;
      let1_r  <= '0;
      seen_r  <= '0;
      line_r  <= cplp_pkg::LINE_FIRST;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      let0_r  <= let0_nxt;
      let1_r  <= let1_nxt;
      seen_r  <= seen_nxt;
      line_r  <= line_nxt;
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    acc_nxt           = acc_r;
    dcnt_nxt          = dcnt_r;
    let0_nxt          = let0_r;
    let1_nxt          = let1_r;
    seen_nxt          = seen_r;
    line_nxt          = line_r;
    emit              = 1'b0;
    res.kind          = cplp_pkg::KIND_RECORD;
    res.code_point    = acc_r;
    res.letter_first  = (32'(seen_r) >= 32'd1) ? let0_r : '0;
    res.letter_second = (32'(seen_r) >= 32'd2) ? let1_r : '0;
    res.letter_count  = cnt;
    res.line_number   = line_r;
    unique case (phase_r)
      cplp_pkg::PH_CODE: begin
        if (hex.ok && 32'(dcnt_r) < DIGITS_MAX) begin
          acc_nxt  = {acc_r[cplp_pkg::CODE_W-5:0], hex.val};
          dcnt_nxt = dcnt_r + DCNT_W'(1);
        end else if (s1_char == cplp_pkg::CHAR_SEMI) begin
          phase_nxt = cplp_pkg::PH_NAME;
        end else begin
          emit              = 1'b1;
          res.kind          = cplp_pkg::KIND_BAD_CODE;
          res.code_point    = '0;
          res.letter_first  = '0;
          res.letter_second = '0;
          res.letter_count  = '0;
          phase_nxt         = cplp_pkg::PH_EOL;
        end
      end
      cplp_pkg::PH_NAME: begin
        if (s1_char == cplp_pkg::CHAR_SEMI) begin
          phase_nxt = cplp_pkg::PH_LETTER;
        end
      end
      cplp_pkg::PH_LETTER: begin
        if (cplp_pkg::is_letter(s1_char) && 32'(seen_r) < LETTERS_MAX) begin
          if (32'(seen_r) == 32'd0) begin
            let0_nxt = s1_char;
          end
          if (32'(seen_r) == 32'd1) begin
            let1_nxt = s1_char;
          end
          seen_nxt = seen_r + LCNT_W'(1);
        end else if (s1_char == cplp_pkg::CHAR_SEMI) begin
          emit      = 1'b1;
          res.kind  = cplp_pkg::KIND_RECORD;
          phase_nxt = cplp_pkg::PH_EOL;
        end else begin
          emit      = 1'b1;
          res.kind  = cplp_pkg::KIND_BAD_CAT;
          phase_nxt = cplp_pkg::PH_EOL;
        end
      end
      cplp_pkg::PH_EOL: begin
        if (s1_char == cplp_pkg::CHAR_NEWLINE) begin
          line_nxt  = (line_r == cplp_pkg::LINE_TOP) ? cplp_pkg::LINE_FIRST
                                                     : line_r + cplp_pkg::LINE_W'(1);
          acc_nxt   = '0;
          dcnt_nxt  = '0;
          let0_nxt  = '0;
          let1_nxt  = '0;
          seen_nxt  = '0;
          phase_nxt = cplp_pkg::PH_CODE;
        end
      end
      default: begin
        phase_nxt = cplp_pkg::PH_CODE;
      end
    endcase
  end

  assign res_valid = fire && emit;

  `CPLP_ASSERT(a_line_nonzero, clk, rst_n, line_r != '0)
  `CPLP_ASSERT(a_no_result_at_eol, clk, rst_n, !(res_valid && phase_r == cplp_pkg::PH_EOL))
  `CPLP_ASSERT_NEXT(a_result_to_eol, clk, rst_n, res_valid, phase_r == cplp_pkg::PH_EOL)
  `CPLP_ASSERT(a_seen_bound, clk, rst_n, 32'(seen_r) <= LETTERS_MAX)

endmodule
`default_nettype wire

// File: rtl/cplp_out_stage.sv
// Result register of the character property line parser.
// Depends on cplp_pkg.
`default_nettype none
module cplp_out_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          res_valid,
  input  wire cplp_pkg::result_t             res,
  output logic                               adv,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_kind,
  output logic [cplp_pkg::CODE_W-1:0]        out_code_point,
  output logic [cplp_pkg::CHAR_W-1:0]        out_letter_first,
  output logic [cplp_pkg::CHAR_W-1:0]        out_letter_second,
  output logic [cplp_pkg::CNT_W-1:0]         out_letter_count,
  output logic [cplp_pkg::LINE_W-1:0]        out_line_number
);

  logic              valid_r;
  logic              valid_nxt;
  cplp_pkg::result_t res_r;

  assign adv       = !valid_r || !out_stall;
  assign valid_nxt = adv ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_kind          = res_r.kind;
  assign out_code_point    = res_r.code_point;
  assign out_letter_first  = res_r.letter_first;
  assign out_letter_second = res_r.letter_second;
  assign out_letter_count  = res_r.letter_count;
  assign out_line_number   = res_r.line_number;

endmodule
`default_nettype wire

// File: rtl/char_property_line_parser_unit.sv
// Character property line parser: one text byte per transfer in, zero or one
// record or error per byte out.
// Channels: in_valid/in_stall carry in_char_in; out_valid/out_stall carry the
// result fields. A transfer happens on a clock edge with valid high and stall low.
// Each line is parsed as: hex code point up to DIGITS_MAX digits, ';', name
// field skipped up to ';', up to LETTERS_MAX category letters, ';'. The closing
// ';' gives a record (kind 0); a bad code point byte gives kind 1, a bad
// category byte kind 2. After a result, bytes are dropped until a newline,
// which advances the 20-bit line number (wraps to 1).
// A byte that completes a result shows it on out_* after its input transfer has
// passed the input register and then the result register.
// Throughput: one byte per cycle while out_stall stays low, set by the parse state update.
// Reset (rst_n low, synchronous) empties both registers, returns the parser to
// the code point field and sets the line number to 1.
// A stall on the output holds the result register; the input register then
// fills and in_stall rises, so no byte or result is lost.
// Depends on cplp_pkg, cplp_in_stage, cplp_parse_core and cplp_out_stage.
`default_nettype none
module char_property_line_parser_unit #(
  parameter int DIGITS_MAX  = cplp_pkg::DIGITS_MAX_DEF,
  parameter int LETTERS_MAX = cplp_pkg::LETTERS_MAX_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [cplp_pkg::CHAR_W-1:0] in_char_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       out_kind,
  output logic [cplp_pkg::CODE_W-1:0]      out_code_point,
  output logic [cplp_pkg::CHAR_W-1:0]      out_letter_first,
  output logic [cplp_pkg::CHAR_W-1:0]      out_letter_second,
  output logic [cplp_pkg::CNT_W-1:0]       out_letter_count,
  output logic [cplp_pkg::LINE_W-1:0]      out_line_number
);

  logic                        adv;
  logic                        s1_valid;
  logic [cplp_pkg::CHAR_W-1:0] s1_char;
  logic                        res_valid;
  cplp_pkg::result_t           res;

  cplp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_char_in (in_char_in),
    .adv        (adv),
    .s1_valid   (s1_valid),
    .s1_char    (s1_char)
  );

  cplp_parse_core #(
    .DIGITS_MAX  (DIGITS_MAX),
    .LETTERS_MAX (LETTERS_MAX)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_valid  (s1_valid),
    .s1_char   (s1_char),
    .adv       (adv),
    .res_valid (res_valid),
    .res       (res)
  );

  cplp_out_stage u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .res_valid         (res_valid),
    .res               (res),
    .adv               (adv),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_kind          (out_kind),
    .out_code_point    (out_code_point),
    .out_letter_first  (out_letter_first),
    .out_letter_second (out_letter_second),
    .out_letter_count  (out_letter_count),
    .out_line_number   (out_line_number)
  );

endmodule
`default_nettype wire
